FILE: src/gregorian_date_add_days_core_assert.svh
// ----------------------------------------------------------------------------
// gregorian date add days - assertion macros
// shared assertion forms, clocked on clk and held off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_ADD_DAYS_CORE_ASSERT_SVH
`define GREGORIAN_DATE_ADD_DAYS_CORE_ASSERT_SVH

// same-cycle implication
`define GDADD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gdadd assertion failed");

// next-cycle implication
`define GDADD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gdadd assertion failed");

`endif

FILE: src/gdadd_pkg.sv
// ----------------------------------------------------------------------------
// gdadd_pkg
// types, constants and calendar tables for the date plus days core
// ----------------------------------------------------------------------------
package gdadd_pkg;

	// field widths
	localparam int DayW   = 5;
	localparam int MonthW = 4;
	localparam int YearW  = 14;
	localparam int CountW = 16;
	localparam int DoyW   = 9;
	// year counter carries one extra bit; leap rules use the separate year modulo 400
	localparam int YearExtW = YearW + 1;
	// shared unit operand width
	localparam int AluW = 17;

	// calendar constants
	localparam int YearDays     = 365;
	localparam int LeapYearDays = 366;
	localparam int LeapFebDays  = 29;
	localparam int Century      = 100;
	localparam int YearCycle    = 400;
	localparam int NumMonths    = 12;
	// restoring reduction of a year modulo 400: 400 << 5 covers 14 bits
	localparam int ModSteps     = 6;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MOD,
		S_DOY,
		S_REM,
		S_CMP,
		S_ADDX,
		S_SUBR,
		S_YEAR,
		S_MON
	} state_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t         op;
		logic [AluW-1:0] a;
		logic [AluW-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [AluW-1:0] res;
		logic            ge;
	} alu_rsp_t;

	// days in month by zero-based index, february as common year
	function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] idx);
		logic [DayW-1:0] len;
		case (idx)
			4'd1:    len = 5'd28;
			4'd3:    len = 5'd30;
			4'd5:    len = 5'd30;
			4'd8:    len = 5'd30;
			4'd10:   len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	// days before the first of month m, leap day included; zero for bad months
	function automatic logic [DoyW-1:0] month_base(input logic [MonthW-1:0] m,
			input logic leap);
		logic [DoyW-1:0] base;
		case (m)
			4'd1:    base = 9'd0;
			4'd2:    base = 9'd31;
			4'd3:    base = 9'd59;
			4'd4:    base = 9'd90;
			4'd5:    base = 9'd120;
			4'd6:    base = 9'd151;
			4'd7:    base = 9'd181;
			4'd8:    base = 9'd212;
			4'd9:    base = 9'd243;
			4'd10:   base = 9'd273;
			4'd11:   base = 9'd304;
			4'd12:   base = 9'd334;
			default: base = 9'd0;
		endcase
		if (leap && m > 4'd2 && m <= 4'(NumMonths))
			base = base + 9'd1;
		return base;
	endfunction

	// leap test from the year modulo 400
	function automatic logic is_leap(input logic [YearW-1:0] r);
		logic by_four;
		logic by_century;
		by_four    = (r[1:0] == 2'd0);
		by_century = (r == YearW'(Century)) || (r == YearW'(2 * Century)) ||
		             (r == YearW'(3 * Century)) || (r == '0);
		return (by_four && !by_century) || (r == '0);
	endfunction

	function automatic logic [DoyW-1:0] year_len(input logic leap);
		return leap ? DoyW'(LeapYearDays) : DoyW'(YearDays);
	endfunction

endpackage

FILE: src/gdadd_alu.sv
// ----------------------------------------------------------------------------
// gdadd_alu
// shared add / subtract-compare unit used by every step of the sequencer but idle
// ----------------------------------------------------------------------------
module gdadd_alu
	import gdadd_pkg::*;
(
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [AluW:0] b_ext;
	logic [AluW:0] sum;

	// a + b, or a - b with the sign bit giving the compare
	always_comb begin
		b_ext = {1'b0, req.b};
		if (req.op == ALU_SUB)
			b_ext = ~b_ext;
		sum     = {1'b0, req.a} + b_ext + {{AluW{1'b0}}, (req.op == ALU_SUB)};
		rsp.res = sum[AluW-1:0];
		rsp.ge  = ~sum[AluW];
	end

endmodule

FILE: src/gregorian_date_add_days_core.sv
// ----------------------------------------------------------------------------
// gregorian_date_add_days_core
// adds a day count to a gregorian date, one shared adder under a sequencer
// ----------------------------------------------------------------------------
//  channel | signals                                    | handshake
//  --------+--------------------------------------------+-----------------------
//  input   | start_day start_month start_year days_to_add | in_valid / in_ready
//  output  | end_day end_month end_year                 | out_valid / out_ready
//
//  an item passes accept, 6 steps reducing the year modulo 400, 3 steps for
//  day of year and remainder, an add step or one step per year crossed plus
//  a last year step, and up to 12 month steps, all but accept on the adder.
//  in_ready is high only while the sequencer is idle; the result sits in an
//  output register, so the next item is taken while it waits to be read.
//  arst_n clears the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
`include "gregorian_date_add_days_core_assert.svh"

module gregorian_date_add_days_core
	import gdadd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [DayW-1:0]   start_day,
	input  logic [MonthW-1:0] start_month,
	input  logic [YearW-1:0]  start_year,
	input  logic [CountW-1:0] days_to_add,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DayW-1:0]   end_day,
	output logic [MonthW-1:0] end_month,
	output logic [YearW-1:0]  end_year
);

	state_t              state_q, state_d;
	logic [DayW-1:0]     day_q;
	logic [MonthW-1:0]   month_q;
	logic [YearExtW-1:0] year_q;
	logic [YearW-1:0]    r400_q;
	logic [CountW-1:0]   x_q;
	logic [DoyW-1:0]     off_q;
	logic [DoyW-1:0]     rem_q;
	logic [2:0]          k_q;
	logic [MonthW-1:0]   mi_q;
	logic                out_valid_q;
	logic [DayW-1:0]     end_day_q;
	logic [MonthW-1:0]   end_month_q;
	logic [YearW-1:0]    end_year_q;

	alu_req_t            alu_req;
	alu_rsp_t            alu_rsp;
	logic                leap;
	logic [DoyW-1:0]     ylen;
	logic [DayW-1:0]     mlen;
	logic                in_fire;
	logic                year_more;
	logic                mon_last;
	logic                finish;
	logic [YearW-1:0]    r400_inc;

	gdadd_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// calendar facts for the year being worked on
	assign leap      = is_leap(r400_q);
	assign ylen      = year_len(leap);
	assign mlen      = (mi_q == 4'd1 && leap) ? DayW'(LeapFebDays) : month_len(mi_q);
	assign r400_inc  = (r400_q == YearW'(YearCycle - 1)) ? '0 : r400_q + 1'b1;
	assign in_fire   = in_valid && in_ready;
	assign year_more = alu_rsp.ge && (alu_rsp.res != '0);
	assign mon_last  = !alu_rsp.ge || (alu_rsp.res == '0) ||
	                   (mi_q == MonthW'(NumMonths - 1));

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign end_day   = end_day_q;
	assign end_month = end_month_q;
	assign end_year  = end_year_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// next state and shared unit operands
	always_comb begin
		state_d = state_q;
		alu_req = '{op: ALU_SUB, a: '0, b: '0};
		finish  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire)
					state_d = S_MOD;
			end
			S_MOD: begin
				alu_req = '{op: ALU_SUB, a: AluW'(r400_q), b: AluW'(YearCycle) << k_q};
				if (k_q == '0)
					state_d = S_DOY;
			end
			S_DOY: begin
				alu_req = '{op: ALU_ADD, a: AluW'(day_q), b: AluW'(month_base(month_q, leap))};
				state_d = S_REM;
			end
			S_REM: begin
				alu_req = '{op: ALU_SUB, a: AluW'(ylen), b: AluW'(off_q)};
				state_d = S_CMP;
			end
			S_CMP: begin
				alu_req = '{op: ALU_SUB, a: AluW'(rem_q), b: AluW'(x_q)};
				state_d = alu_rsp.ge ? S_ADDX : S_SUBR;
			end
			S_ADDX: begin
				alu_req = '{op: ALU_ADD, a: AluW'(off_q), b: AluW'(x_q)};
				state_d = S_MON;
			end
			S_SUBR: begin
				alu_req = '{op: ALU_SUB, a: AluW'(x_q), b: AluW'(rem_q)};
				state_d = S_YEAR;
			end
			S_YEAR: begin
				alu_req = '{op: ALU_SUB, a: AluW'(x_q), b: AluW'(ylen)};
				if (!year_more)
					state_d = S_MON;
			end
			S_MON: begin
				alu_req = '{op: ALU_SUB, a: AluW'(off_q), b: AluW'(mlen)};
				// hold on the last month until the output register is free
				if (mon_last && (!out_valid_q || out_ready)) begin
					finish  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					day_q   <= start_day;
					month_q <= start_month;
					year_q  <= {1'b0, start_year};
					r400_q  <= start_year;
					x_q     <= days_to_add;
					k_q     <= 3'(ModSteps - 1);
				end
			end
			S_MOD: begin
				if (alu_rsp.ge)
					r400_q <= alu_rsp.res[YearW-1:0];
				k_q <= k_q - 1'b1;
			end
			S_DOY: off_q <= alu_rsp.res[DoyW-1:0];
			S_REM: rem_q <= alu_rsp.ge ? alu_rsp.res[DoyW-1:0] : '0;
			S_CMP: mi_q  <= '0;
			S_ADDX: off_q <= alu_rsp.res[DoyW-1:0];
			S_SUBR: begin
				x_q    <= alu_rsp.res[CountW-1:0];
				year_q <= year_q + 1'b1;
				r400_q <= r400_inc;
			end
			S_YEAR: begin
				if (year_more) begin
					x_q    <= alu_rsp.res[CountW-1:0];
					year_q <= year_q + 1'b1;
					r400_q <= r400_inc;
				end else begin
					off_q <= x_q[DoyW-1:0];
				end
			end
			S_MON: begin
				if (!mon_last) begin
					off_q <= alu_rsp.res[DoyW-1:0];
					mi_q  <= mi_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (finish) begin
			end_day_q   <= off_q[DayW-1:0];
			end_month_q <= mi_q + 1'b1;
			end_year_q  <= year_q[YearW-1:0];
		end
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (finish)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// checks on the sequencer
	`GDADD_ASSERT_NEXT(a_accept_starts_mod, in_fire, state_q == S_MOD)
	`GDADD_ASSERT_NOW(a_year_reduced, state_q == S_YEAR, r400_q < YearW'(YearCycle))
	`GDADD_ASSERT_NOW(a_month_in_range, state_q == S_MON, mi_q < MonthW'(NumMonths))
	`GDADD_ASSERT_NEXT(a_finish_sets_valid, finish, out_valid_q && state_q == S_IDLE)

endmodule

FILE: tb/gregorian_date_add_days_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gregorian_date_add_days_core_tb
// drives dates and day counts into the core, predicts each resulting date
// from a typed-in result or a calendar model of its own, checks every
// result in order; a short table of calendar corner cases comes first,
// then random traffic with bursty input and a stalling receiver
// ----------------------------------------------------------------------------
module gregorian_date_add_days_core_tb
	import gdadd_pkg::*;
();

	localparam int NumDirected  = 20;
	localparam int RandomItems  = 1580;
	localparam int DrainCycles  = 250;
	localparam int CycleLimit   = 3000000;

	typedef struct packed {
		logic [DayW-1:0]   day;
		logic [MonthW-1:0] month;
		logic [YearW-1:0]  year;
	} date_t;

	typedef struct packed {
		logic [DayW-1:0]   day;
		logic [MonthW-1:0] month;
		logic [YearW-1:0]  year;
		logic [CountW-1:0] count;
		logic              known;
		date_t             want;
	} stim_row_t;

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_MOSTLY,
		READY_RARELY
	} ready_mode_t;

	// month lengths of a common year
	localparam int unsigned CommonMonthDays [12] = '{
		31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
	};

	// calendar corner cases; results typed in only where obvious
	localparam stim_row_t DirectedRows [NumDirected] = '{
		'{5'd1,  4'd1,  14'd2000,  16'd0,     1'b1, '{5'd1,  4'd1,  14'd2000}},
		'{5'd31, 4'd12, 14'd1999,  16'd1,     1'b1, '{5'd1,  4'd1,  14'd2000}},
		'{5'd28, 4'd2,  14'd2000,  16'd1,     1'b0, '{5'd0,  4'd0,  14'd0}},
		'{5'd28, 4'd2,  14'd1900,  16'd1,     1'b0, '{5'd0,  4'd0,  14'd0}},
		'{5'd29, 4'd2,  14'd2024,  16'd365,   1'b0, '{5'd0,  4'd0,  14'd0}},
		'{5'd30, 4'd2,  14'd2023,  16'd0,     1'b1, '{5'd2,  4'd3,  14'd2023}},
		'{5'd0,  4'd1,  14'd2023,  16'd0,     1'b1, '{5'd0,  4'd1,  14'd2023}},
		'{5'd0,  4'd3,  14'd2023,  16'd0,     1'b0, '{5'd0,  4'd0,  14'd0}},
		'{5'd15, 4'd0,  14'd2023,  16'd0,     1'b1, '{5'd15, 4'd1,  14'd2023}},
		'{5'd15, 4'd13, 14'd2024,  16'd0,     1'b1, '{5'd15, 4'd1,  14'd2024}},
		'{5'd31, 4'd15, 14'd16383, 16'd65535, 1'b0, '{5'd0,  4'd0,  14'd0}},
		'{5'd0,  4'd0,  14'd0,     16'd0,     1'b1, '{5'd0,  4'd1,  14'd0}},
		'{5'd1,  4'd3,  14'd0,     16'd0,     1'b0, '{5'd0,  4'd0,  14'd0}},
		'{5'd31, 4'd12, 14'd9999,  16'd1,     1'b1, '{5'd1,  4'd1,  14'd10000}},
		'{5'd31, 4'd12, 14'd16383, 16'd1,     1'b1, '{5'd1,  4'd1,  14'd0}},
		'{5'd31, 4'd12, 14'd2023,  16'd366,   1'b1, '{5'd31, 4'd12, 14'd2024}},
		'{5'd1,  4'd1,  14'd2023,  16'd365,   1'b1, '{5'd1,  4'd1,  14'd2024}},
		'{5'd1,  4'd1,  14'd1,     16'd65535, 1'b0, '{5'd0,  4'd0,  14'd0}},
		'{5'd31, 4'd12, 14'd9999,  16'd65535, 1'b0, '{5'd0,  4'd0,  14'd0}},
		'{5'd31, 4'd1,  14'd2100,  16'd29,    1'b0, '{5'd0,  4'd0,  14'd0}}
	};

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_ready;
	logic [DayW-1:0]   start_day   = '0;
	logic [MonthW-1:0] start_month = '0;
	logic [YearW-1:0]  start_year  = '0;
	logic [CountW-1:0] days_to_add = '0;
	logic              out_valid;
	logic              out_ready   = 1'b0;
	logic [DayW-1:0]   end_day;
	logic [MonthW-1:0] end_month;
	logic [YearW-1:0]  end_year;

	date_t       awaited_dates [$];
	int          mismatches     = 0;
	int          items_sent     = 0;
	int          results_seen   = 0;
	int          years_crossed  = 0;
	int          odd_dates      = 0;
	int          burst_left     = 0;
	int unsigned cycles         = 0;
	ready_mode_t ready_mode     = READY_ALWAYS;
	int          ready_mode_left = 0;

	gregorian_date_add_days_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.start_day   (start_day),
		.start_month (start_month),
		.start_year  (start_year),
		.days_to_add (days_to_add),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.end_day     (end_day),
		.end_month   (end_month),
		.end_year    (end_year)
	);

	always #5 clk = ~clk;

	// 4/100/400 rule on the unwrapped year
	function automatic bit is_gregorian_leap(input int unsigned y);
		return ((y % 4) == 0 && (y % Century) != 0) || (y % YearCycle) == 0;
	endfunction

	function automatic int unsigned days_in_year(input int unsigned y);
		return is_gregorian_leap(y) ? LeapYearDays : YearDays;
	endfunction

	// resulting date for a start date plus a day count
	function automatic date_t add_days_to_date(input logic [DayW-1:0] d,
			input logic [MonthW-1:0] m, input logic [YearW-1:0] y,
			input logic [CountW-1:0] n);
		int unsigned doy;
		int unsigned room;
		int unsigned left;
		int unsigned yr;
		int unsigned mlen;
		int unsigned mi;
		date_t       r;
		doy = 32'(d);
		// bad months add no month offset and no leap day
		if (m >= 1 && m <= NumMonths) begin
			for (int k = 0; k < int'(m) - 1; k++)
				doy += CommonMonthDays[k];
			if (m > 2 && is_gregorian_leap(32'(y)))
				doy++;
		end
		room = (days_in_year(32'(y)) >= doy) ? days_in_year(32'(y)) - doy : 0;
		left = 32'(n);
		yr   = 32'(y);
		// whole years, stepping on only while strictly more than a year is left
		if (left <= room) begin
			doy += left;
		end else begin
			left -= room;
			yr++;
			while (left > days_in_year(yr)) begin
				left -= days_in_year(yr);
				yr++;
			end
			doy = left;
		end
		// walk the months; december takes whatever is left
		mi = 0;
		while (mi < NumMonths - 1) begin
			mlen = (mi == 1 && is_gregorian_leap(yr)) ? LeapFebDays : CommonMonthDays[mi];
			if (doy <= mlen)
				break;
			doy -= mlen;
			mi++;
		end
		r.day   = DayW'(doy);
		r.month = MonthW'(mi + 1);
		r.year  = YearW'(yr);
		return r;
	endfunction

	// present one item in bursts, wait for the handshake, queue its expected result
	task automatic send_date(input logic [DayW-1:0] d, input logic [MonthW-1:0] m,
			input logic [YearW-1:0] y, input logic [CountW-1:0] n,
			input logic known, input date_t want);
		int    gap;
		date_t due;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 60);
		end
		burst_left--;
		start_day   = d;
		start_month = m;
		start_year  = y;
		days_to_add = n;
		in_valid    = 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		due = known ? want : add_days_to_date(d, m, y, n);
		awaited_dates.push_back(due);
		items_sent++;
		if (due.year != y)
			years_crossed++;
		if (d == 0 || m == 0 || m > NumMonths || y == 0 || y > 9999)
			odd_dates++;
	endtask

	task automatic wait_for_results();
		while (awaited_dates.size() != 0)
			@(negedge clk);
	endtask

	// receiver stalls, picking a new habit each time its countdown runs out
	always @(negedge clk) begin
		if (ready_mode_left == 0) begin
			ready_mode      = ready_mode_t'($urandom_range(0, 2));
			ready_mode_left = $urandom_range(50, 400);
		end else begin
			ready_mode_left--;
		end
		case (ready_mode)
			READY_ALWAYS: out_ready = 1'b1;
			READY_MOSTLY: out_ready = ($urandom_range(0, 2) != 0);
			default:      out_ready = ($urandom_range(0, 5) == 0);
		endcase
	end

	// compare each result with the oldest pending date
	always @(posedge clk) begin : check_results
		date_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_dates.size() == 0) begin
				$error("result %0d/%0d/%0d with no item pending", end_day, end_month, end_year);
				mismatches++;
			end else begin
				want = awaited_dates.pop_front();
				results_seen++;
				if (end_day !== want.day) begin
					$error("end_day: expected %0d, got %0d", want.day, end_day);
					mismatches++;
				end
				if (end_month !== want.month) begin
					$error("end_month: expected %0d, got %0d", want.month, end_month);
					mismatches++;
				end
				if (end_year !== want.year) begin
					$error("end_year: expected %0d, got %0d", want.year, end_year);
					mismatches++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CycleLimit) begin
			$error("timed out with %0d results pending", awaited_dates.size());
			$display("gregorian_date_add_days_core_tb: errors");
			$finish;
		end
	end

	// stimulus
	initial begin : drive_dates
		logic [DayW-1:0]   d;
		logic [MonthW-1:0] m;
		logic [YearW-1:0]  y;
		logic [CountW-1:0] n;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < NumDirected; i++)
			send_date(DirectedRows[i].day, DirectedRows[i].month, DirectedRows[i].year,
				DirectedRows[i].count, DirectedRows[i].known, DirectedRows[i].want);
		// hold off until the core has drained
		@(negedge clk);
		in_valid = 1'b0;
		wait_for_results();

		for (int i = 0; i < RandomItems; i++) begin
			if ($urandom_range(0, 9) < 7) begin
				// in-range fields (feb 29 in any year) with counts of assorted reach
				m = MonthW'($urandom_range(1, 12));
				d = DayW'($urandom_range(1, (m == 2) ? LeapFebDays : CommonMonthDays[m - 1]));
				y = YearW'($urandom_range(1, 9999));
				case ($urandom_range(0, 3))
					0:       n = CountW'($urandom_range(0, 31));
					1:       n = CountW'($urandom_range(0, 800));
					2:       n = CountW'($urandom_range(360, 370));
					default: n = CountW'($urandom_range(0, 65535));
				endcase
			end else begin
				// anything the field widths allow
				d = DayW'($urandom_range(0, 31));
				m = MonthW'($urandom_range(0, 15));
				y = YearW'($urandom_range(0, 16383));
				n = CountW'($urandom_range(0, 65535));
			end
			if (i == RandomItems / 2) begin
				@(negedge clk);
				in_valid = 1'b0;
				wait_for_results();
			end
			send_date(d, m, y, n, 1'b0, '0);
		end
		@(negedge clk);
		in_valid = 1'b0;

		wait_for_results();
		repeat (DrainCycles) @(posedge clk);
		if (awaited_dates.size() != 0) begin
			$error("%0d results never arrived", awaited_dates.size());
			mismatches++;
		end
		$display("%0d items sent, %0d results checked in %0d cycles", items_sent,
			results_seen, cycles);
		$display("%0d crossed into a later year, %0d had an out-of-range day, month or year",
			years_crossed, odd_dates);
		if (mismatches == 0)
			$display("gregorian_date_add_days_core_tb: clean");
		else
			$display("gregorian_date_add_days_core_tb: errors");
		$finish;
	end

endmodule
